>>> rtl/slg_pkg.sv
// Package for the shuffled Lehmer uniform generator.
// Holds generator constants, table sizing, sequencer states and the table write struct.
// No dependencies.
package slg_pkg;

	localparam int TABLE_SIZE = 32;
	localparam int TBL_AW = $clog2(TABLE_SIZE);
	localparam int VAL_W = 31;
	localparam int MUL_W = 15;
	localparam int PROD_W = VAL_W + MUL_W;
	localparam int WARM_STEPS = TABLE_SIZE + 8;
	localparam int CNT_W = $clog2(WARM_STEPS);

	localparam logic [MUL_W-1:0] LCG_MUL = 15'd16807;
	localparam logic [VAL_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SEED_RESET = 31'd3476;
	localparam logic [CNT_W-1:0] WARM_LAST = CNT_W'(WARM_STEPS - 1);
	localparam logic [CNT_W-1:0] TABLE_LIMIT = CNT_W'(TABLE_SIZE);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_MUL  = 3'b010,
		S_FOLD = 3'b100
	} state_t;

	typedef struct packed {
		logic              en;
		logic [TBL_AW-1:0] addr;
		logic [VAL_W-1:0]  data;
	} tbl_wr_t;

endpackage

>>> rtl/slg_lcg_unit.sv
// Shared Lehmer step unit: registered multiply by 16807, then fold modulo 2^31-1.
// The product is registered on load; the fold is combinational. Depends on slg_pkg.
module slg_lcg_unit import slg_pkg::*; (
	input  logic             clk,
	input  logic             load,
	input  logic [VAL_W-1:0] x,
	output logic [VAL_W-1:0] y
);

	logic [PROD_W-1:0] prod_q;
	logic [VAL_W:0]    sum;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PROD_W'(x) * PROD_W'(LCG_MUL);
		end
	end

	always_comb begin
		sum = {1'b0, prod_q[VAL_W-1:0]} + (VAL_W+1)'(prod_q[PROD_W-1:VAL_W]);
		if (sum >= {1'b0, LCG_MOD}) begin
			sum = sum - {1'b0, LCG_MOD};
		end
		y = sum[VAL_W-1:0];
	end

endmodule

>>> rtl/slg_table.sv
// Shuffle table memory with one write port and one registered read port.
// Depends on slg_pkg.
module slg_table import slg_pkg::*; (
	input  logic              clk,
	input  tbl_wr_t           wr,
	input  logic [TBL_AW-1:0] rd_addr,
	output logic [VAL_W-1:0]  rd_data
);

	logic [VAL_W-1:0] mem [TABLE_SIZE];
	logic [VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/shuffled_lcg_uniform_generator_unit.sv
// A plain request runs one step of the shared step unit and returns the table word it reads;
// a reseed request, or the first after reset, first runs 40 warm-up steps of the step unit.
// Requests are taken only in the idle state, and an output stall holds the fold step.
// Reset clears control state, restores the seed register to 3476 and marks the table
// stale, so the first request after reset reinitializes the generator.
// Depends on slg_pkg, slg_lcg_unit and slg_table.
module shuffled_lcg_uniform_generator_unit import slg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [VAL_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             reseed,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [VAL_W-1:0] value
);

	state_t           state_q;
	logic [VAL_W-1:0] seed_q;
	logic [VAL_W-1:0] s_q;
	logic [VAL_W-1:0] last_q;
	logic [VAL_W-1:0] value_q;
	logic             out_valid_q;
	logic             init_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VAL_W-1:0] step_y;
	logic [VAL_W-1:0] rd_data;
	logic [VAL_W-1:0] seed_clean;
	logic             accept;
	logic             fold_go;
	tbl_wr_t          wr;

	assign accept = in_valid && (state_q == S_IDLE);
	assign fold_go = (state_q == S_FOLD) && (init_q || !out_valid_q || !out_stall);
	assign seed_clean = (seed_q == '0 || seed_q == LCG_MOD) ? VAL_W'(1) : seed_q;

	always_comb begin
		wr.en = 1'b0;
		wr.addr = cnt_q[TBL_AW-1:0];
		wr.data = step_y;
		if (fold_go) begin
			if (init_q) begin
				wr.en = cnt_q < TABLE_LIMIT;
			end else begin
				wr.en = 1'b1;
				wr.addr = last_q[VAL_W-1 -: TBL_AW];
			end
		end
	end

	slg_lcg_unit u_step (
		.clk  (clk),
		.load (state_q == S_MUL),
		.x    (s_q),
		.y    (step_y)
	);

	slg_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (last_q[VAL_W-1 -: TBL_AW]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			seed_q <= SEED_RESET;
			last_q <= '0;
			out_valid_q <= 1'b0;
			init_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_data;
			end
			if (fold_go && !init_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						init_q <= reseed || (last_q == '0);
						cnt_q <= WARM_LAST;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					if (fold_go) begin
						if (init_q) begin
							state_q <= S_MUL;
							if (cnt_q == '0) begin
								init_q <= 1'b0;
								last_q <= step_y;
							end else begin
								cnt_q <= cnt_q - 1'b1;
							end
						end else begin
							last_q <= rd_data;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (reseed || last_q == '0)) begin
			s_q <= seed_clean;
		end else if (fold_go) begin
			s_q <= step_y;
		end
		if (fold_go && !init_q) begin
			value_q <= rd_data;
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign value = value_q;

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (value != '0 && value != LCG_MOD))
		else $error("output word outside the generator range");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_MUL))
		else $error("accepted request did not start a step");

	a_warm_count: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> (cnt_q <= WARM_LAST))
		else $error("warm-up counter out of range");
`endif

endmodule
